@@ sv/ffsc_pkg.sv @@
// Shared types, constants and membership set-up functions of the fuzzy fan speed controller.
package ffsc_pkg;

   localparam int unsigned CSR_INDEX_W = 8;
   localparam int unsigned WORD_W      = 16;
   localparam int unsigned SPAN_W      = 9;
   localparam int unsigned SUM_W       = 17;

   localparam logic [CSR_INDEX_W-1:0] CSR_SPEED_LOW  = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPEED_MID  = 8'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPEED_HIGH = 8'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_THRESHOLD  = 8'd3;

   localparam logic [WORD_W-1:0] Q_ONE     = 16'h8000;
   localparam logic [SUM_W-1:0]  SUM_FLOOR = 17'd33;

   localparam logic [3:0] RAMP_LAST = 4'd14;
   localparam logic [3:0] MULT_LAST = 4'd15;
   localparam logic [3:0] DIV_LAST  = 4'd15;

   localparam logic signed [12:0] COOL_A  = 13'sd352;
   localparam logic signed [12:0] COOL_B  = 13'sd416;
   localparam logic signed [12:0] WARM_A  = 13'sd384;
   localparam logic signed [12:0] WARM_M  = 13'sd432;
   localparam logic signed [12:0] WARM_B  = 13'sd480;
   localparam logic signed [12:0] HOT_A   = 13'sd448;
   localparam logic signed [12:0] HOT_B   = 13'sd512;
   localparam logic signed [12:0] DRY_A   = 13'sd640;
   localparam logic signed [12:0] DRY_B   = 13'sd880;
   localparam logic signed [12:0] COMFY_A = 13'sd640;
   localparam logic signed [12:0] COMFY_P = 13'sd800;
   localparam logic signed [12:0] COMFY_Q = 13'sd960;
   localparam logic signed [12:0] COMFY_B = 13'sd1120;
   localparam logic signed [12:0] WET_A   = 13'sd960;
   localparam logic signed [12:0] WET_B   = 13'sd1280;

   typedef enum logic [1:0] {
      LVL_ZERO,
      LVL_ONE,
      LVL_RAMP
   } lvl_mode_type;

   typedef struct packed {
      lvl_mode_type      mode;
      logic [SPAN_W-1:0] gap;
      logic [SPAN_W-1:0] span;
   } ramp_setup_type;

   typedef struct packed {
      logic load;
      logic step;
   } unit_ctl_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RAMP,
      ST_WEIGH,
      ST_MULT,
      ST_DLOAD,
      ST_DIVIDE,
      ST_FINISH
   } state_type;

   function automatic ramp_setup_type rise_setup(input logic signed [12:0] x,
                                                 input logic signed [12:0] a,
                                                 input logic signed [12:0] b);
      ramp_setup_type   s;
      logic signed [12:0] d;
      logic signed [12:0] w;
      d      = x - a;
      w      = b - a;
      s.gap  = d[SPAN_W-1:0];
      s.span = w[SPAN_W-1:0];
      if (x <= a) begin
         s.mode = LVL_ZERO;
      end else if (x >= b) begin
         s.mode = LVL_ONE;
      end else begin
         s.mode = LVL_RAMP;
      end
      return s;
   endfunction

   function automatic ramp_setup_type fall_setup(input logic signed [12:0] x,
                                                 input logic signed [12:0] a,
                                                 input logic signed [12:0] b);
      ramp_setup_type   s;
      logic signed [12:0] d;
      logic signed [12:0] w;
      d      = b - x;
      w      = b - a;
      s.gap  = d[SPAN_W-1:0];
      s.span = w[SPAN_W-1:0];
      if (x <= a) begin
         s.mode = LVL_ONE;
      end else if (x >= b) begin
         s.mode = LVL_ZERO;
      end else begin
         s.mode = LVL_RAMP;
      end
      return s;
   endfunction

   function automatic ramp_setup_type warm_setup(input logic signed [12:0] x);
      ramp_setup_type s;
      s = rise_setup(x, WARM_A, WARM_M);
      if (x <= WARM_A || x >= WARM_B) begin
         s.mode = LVL_ZERO;
      end else if (x >= WARM_M) begin
         s = fall_setup(x, WARM_M, WARM_B);
      end
      return s;
   endfunction

   function automatic ramp_setup_type comfy_setup(input logic signed [12:0] x);
      ramp_setup_type s;
      s = rise_setup(x, COMFY_A, COMFY_P);
      if (x <= COMFY_A || x >= COMFY_B) begin
         s.mode = LVL_ZERO;
      end else if (x >= COMFY_P && x <= COMFY_Q) begin
         s.mode = LVL_ONE;
      end else if (x > COMFY_Q) begin
         s = fall_setup(x, COMFY_Q, COMFY_B);
      end
      return s;
   endfunction

endpackage

@@ sv/ffsc_if.sv @@
// Handshake interfaces for the request, response and register write channels.
interface ffsc_req_if;
   logic              valid;
   logic              ready;
   logic signed [11:0] temperature;
   logic [10:0]       humidity;
   logic              presence;
   logic              auto_mode;
   modport source (output valid, temperature, humidity, presence, auto_mode, input ready);
   modport sink (input valid, temperature, humidity, presence, auto_mode, output ready);
endinterface

interface ffsc_rsp_if;
   logic        valid;
   logic        ready;
   logic        fan_on;
   logic [15:0] pwm_value;
   modport source (output valid, fan_on, pwm_value, input ready);
   modport sink (input valid, fan_on, pwm_value, output ready);
endinterface

interface ffsc_csr_if;
   logic        valid;
   logic        ready;
   logic [7:0]  reg_index;
   logic [15:0] wdata;
   modport source (output valid, reg_index, wdata, input ready);
   modport sink (input valid, reg_index, wdata, output ready);
endinterface

@@ sv/ffsc_ramp_lane.sv @@
// Bit-serial membership lane: one quotient bit of distance times one over span per cycle.
module ffsc_ramp_lane (
   input  logic                   clock,
   input  ffsc_pkg::unit_ctl_type ctl,
   input  ffsc_pkg::ramp_setup_type setup,
   output logic [15:0]            level
);

   ffsc_pkg::lvl_mode_type mode_ff, mode_in;
   logic [8:0]  span_ff, span_in;
   logic [8:0]  rem_ff, rem_in;
   logic [14:0] quo_ff, quo_in;
   logic [9:0]  rem_dbl;

   always_comb begin
      mode_in = mode_ff;
      span_in = span_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      rem_dbl = {rem_ff, 1'b0};
      if (ctl.load) begin
         mode_in = setup.mode;
         span_in = setup.span;
         rem_in  = setup.gap;
         quo_in  = '0;
      end else if (ctl.step) begin
         if (rem_dbl >= {1'b0, span_ff}) begin
            rem_in = 9'(rem_dbl - {1'b0, span_ff});
            quo_in = {quo_ff[13:0], 1'b1};
         end else begin
            rem_in = rem_dbl[8:0];
            quo_in = {quo_ff[13:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      mode_ff <= mode_in;
      span_ff <= span_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
   end

   always_comb begin
      case (mode_ff)
         ffsc_pkg::LVL_ONE:  level = ffsc_pkg::Q_ONE;
         ffsc_pkg::LVL_RAMP: level = {1'b0, quo_ff};
         default:            level = '0;
      endcase
   end

endmodule

@@ sv/ffsc_mac.sv @@
// Bit-serial weighted sum of the three speed registers, most significant speed bit first.
module ffsc_mac (
   input  logic                   clock,
   input  ffsc_pkg::unit_ctl_type ctl,
   input  logic [15:0]            w_low,
   input  logic [15:0]            w_mid,
   input  logic [15:0]            w_high,
   input  logic [15:0]            rate_low,
   input  logic [15:0]            rate_mid,
   input  logic [15:0]            rate_high,
   output logic [32:0]            num,
   output logic [16:0]            sum
);

   logic [15:0] wl_ff, wl_in, wm_ff, wm_in, wh_ff, wh_in;
   logic [15:0] sl_ff, sl_in, sm_ff, sm_in, sh_ff, sh_in;
   logic [32:0] acc_ff, acc_in;
   logic [16:0] partial;

   always_comb begin
      wl_in   = wl_ff;
      wm_in   = wm_ff;
      wh_in   = wh_ff;
      sl_in   = sl_ff;
      sm_in   = sm_ff;
      sh_in   = sh_ff;
      acc_in  = acc_ff;
      partial = (sl_ff[15] ? {1'b0, wl_ff} : 17'd0)
              + (sm_ff[15] ? {1'b0, wm_ff} : 17'd0)
              + (sh_ff[15] ? {1'b0, wh_ff} : 17'd0);
      if (ctl.load) begin
         wl_in  = w_low;
         wm_in  = w_mid;
         wh_in  = w_high;
         sl_in  = rate_low;
         sm_in  = rate_mid;
         sh_in  = rate_high;
         acc_in = '0;
      end else if (ctl.step) begin
         sl_in  = {sl_ff[14:0], 1'b0};
         sm_in  = {sm_ff[14:0], 1'b0};
         sh_in  = {sh_ff[14:0], 1'b0};
         acc_in = {acc_ff[31:0], 1'b0} + {16'd0, partial};
      end
   end

   always_ff @(posedge clock) begin
      wl_ff  <= wl_in;
      wm_ff  <= wm_in;
      wh_ff  <= wh_in;
      sl_ff  <= sl_in;
      sm_ff  <= sm_in;
      sh_ff  <= sh_in;
      acc_ff <= acc_in;
   end

   assign num = acc_ff;
   assign sum = {1'b0, wl_ff} + {1'b0, wm_ff} + {1'b0, wh_ff};

endmodule

@@ sv/ffsc_divider.sv @@
// Restoring serial divider giving a sixteen-bit quotient, one bit per cycle.
module ffsc_divider (
   input  logic                   clock,
   input  ffsc_pkg::unit_ctl_type ctl,
   input  logic [32:0]            num,
   input  logic [16:0]            den,
   output logic [15:0]            quotient
);

   logic [16:0] den_ff, den_in;
   logic [16:0] rem_ff, rem_in;
   logic [15:0] lo_ff, lo_in;
   logic [17:0] rem_dbl;

   always_comb begin
      den_in  = den_ff;
      rem_in  = rem_ff;
      lo_in   = lo_ff;
      rem_dbl = {rem_ff, lo_ff[15]};
      if (ctl.load) begin
         den_in = den;
         rem_in = num[32:16];
         lo_in  = num[15:0];
      end else if (ctl.step) begin
         if (rem_dbl >= {1'b0, den_ff}) begin
            rem_in = 17'(rem_dbl - {1'b0, den_ff});
            lo_in  = {lo_ff[14:0], 1'b1};
         end else begin
            rem_in = rem_dbl[16:0];
            lo_in  = {lo_ff[14:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      den_ff <= den_in;
      rem_ff <= rem_in;
      lo_ff  <= lo_in;
   end

   assign quotient = lo_ff;

endmodule

@@ sv/fuzzy_fan_speed_controller.sv @@
// Top level of the fuzzy fan speed controller: registers, sequencer and result register.
// An item in automatic mode with someone present goes from acceptance to its result
// through bit-serial membership division in six parallel lanes, bit-serial
// multiply-accumulate over the speed registers and restoring division by the weight
// sum, with the weigh, divider-load and finish states as hand-over steps. When the
// weight sum is below 33 the division is skipped; an item in manual mode or with
// nobody present goes straight to the finish state. The next item is accepted in the
// cycle after a result is loaded, even while that result still waits to be taken. Register
// writes are always accepted and should only be made while no item is in progress.
module fuzzy_fan_speed_controller (
   input logic      clock,
   input logic      reset,
   ffsc_req_if.sink   req_bus,
   ffsc_rsp_if.source rsp_bus,
   ffsc_csr_if.sink   csr_bus
);

   ffsc_pkg::state_type state_ff, state_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic [15:0] speed_low_ff, speed_mid_ff, speed_high_ff, threshold_ff;
   logic [15:0] held_pwm_ff, held_pwm_in;
   logic        fan_en_ff, fan_en_in;
   logic        auto_ff, present_ff, use_div_ff;
   logic [15:0] next_pwm_ff;
   logic        rsp_valid_ff, rsp_fan_ff;
   logic [15:0] rsp_pwm_ff;

   logic        accept, run, out_free, finish_fire, sum_small;
   logic signed [12:0] temp_x, humid_x;
   ffsc_pkg::unit_ctl_type lane_ctl, mac_ctl, div_ctl;
   ffsc_pkg::ramp_setup_type cool_s, warm_s, hot_s, dry_s, comfy_s, wet_s;
   logic [15:0] cool_l, warm_l, hot_l, dry_l, comfy_l, wet_l;
   logic [15:0] w_low, w_mid, w_high;
   logic [32:0] mac_num;
   logic [16:0] mac_sum;
   logic [15:0] quotient, cand, diff;

   assign accept      = req_bus.valid && req_bus.ready;
   assign run         = req_bus.auto_mode && req_bus.presence;
   assign out_free    = !rsp_valid_ff || rsp_bus.ready;
   assign finish_fire = (state_ff == ffsc_pkg::ST_FINISH) && out_free;
   assign sum_small   = mac_sum < ffsc_pkg::SUM_FLOOR;

   assign temp_x  = $signed({req_bus.temperature[11], req_bus.temperature});
   assign humid_x = $signed({2'b00, req_bus.humidity});

   assign cool_s  = ffsc_pkg::fall_setup(temp_x, ffsc_pkg::COOL_A, ffsc_pkg::COOL_B);
   assign warm_s  = ffsc_pkg::warm_setup(temp_x);
   assign hot_s   = ffsc_pkg::rise_setup(temp_x, ffsc_pkg::HOT_A, ffsc_pkg::HOT_B);
   assign dry_s   = ffsc_pkg::fall_setup(humid_x, ffsc_pkg::DRY_A, ffsc_pkg::DRY_B);
   assign comfy_s = ffsc_pkg::comfy_setup(humid_x);
   assign wet_s   = ffsc_pkg::rise_setup(humid_x, ffsc_pkg::WET_A, ffsc_pkg::WET_B);

   ffsc_ramp_lane u_cool  (.clock(clock), .ctl(lane_ctl), .setup(cool_s),  .level(cool_l));
   ffsc_ramp_lane u_warm  (.clock(clock), .ctl(lane_ctl), .setup(warm_s),  .level(warm_l));
   ffsc_ramp_lane u_hot   (.clock(clock), .ctl(lane_ctl), .setup(hot_s),   .level(hot_l));
   ffsc_ramp_lane u_dry   (.clock(clock), .ctl(lane_ctl), .setup(dry_s),   .level(dry_l));
   ffsc_ramp_lane u_comfy (.clock(clock), .ctl(lane_ctl), .setup(comfy_s), .level(comfy_l));
   ffsc_ramp_lane u_wet   (.clock(clock), .ctl(lane_ctl), .setup(wet_s),   .level(wet_l));

   assign w_low  = (cool_l > dry_l)  ? cool_l : dry_l;
   assign w_mid  = (warm_l > comfy_l) ? warm_l : comfy_l;
   assign w_high = (hot_l > wet_l)   ? hot_l : wet_l;

   ffsc_mac u_mac (
      .clock      (clock),
      .ctl        (mac_ctl),
      .w_low      (w_low),
      .w_mid      (w_mid),
      .w_high     (w_high),
      .rate_low   (speed_low_ff),
      .rate_mid   (speed_mid_ff),
      .rate_high  (speed_high_ff),
      .num        (mac_num),
      .sum        (mac_sum)
   );

   ffsc_divider u_div (
      .clock    (clock),
      .ctl      (div_ctl),
      .num      (mac_num),
      .den      (mac_sum),
      .quotient (quotient)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ffsc_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = run ? ffsc_pkg::ST_RAMP : ffsc_pkg::ST_FINISH;
            end
         end
         ffsc_pkg::ST_RAMP: begin
            if (cnt_ff == ffsc_pkg::RAMP_LAST) state_in = ffsc_pkg::ST_WEIGH;
         end
         ffsc_pkg::ST_WEIGH: state_in = ffsc_pkg::ST_MULT;
         ffsc_pkg::ST_MULT: begin
            if (cnt_ff == ffsc_pkg::MULT_LAST) state_in = ffsc_pkg::ST_DLOAD;
         end
         ffsc_pkg::ST_DLOAD: begin
            state_in = sum_small ? ffsc_pkg::ST_FINISH : ffsc_pkg::ST_DIVIDE;
         end
         ffsc_pkg::ST_DIVIDE: begin
            if (cnt_ff == ffsc_pkg::DIV_LAST) state_in = ffsc_pkg::ST_FINISH;
         end
         ffsc_pkg::ST_FINISH: begin
            if (out_free) state_in = ffsc_pkg::ST_IDLE;
         end
         default: state_in = ffsc_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_bus.ready = 1'b0;
      lane_ctl      = '0;
      mac_ctl       = '0;
      div_ctl       = '0;
      case (state_ff)
         ffsc_pkg::ST_IDLE: begin
            req_bus.ready = 1'b1;
            lane_ctl.load = req_bus.valid && run;
         end
         ffsc_pkg::ST_RAMP:   lane_ctl.step = 1'b1;
         ffsc_pkg::ST_WEIGH:  mac_ctl.load  = 1'b1;
         ffsc_pkg::ST_MULT:   mac_ctl.step  = 1'b1;
         ffsc_pkg::ST_DLOAD:  div_ctl.load  = !sum_small;
         ffsc_pkg::ST_DIVIDE: div_ctl.step  = 1'b1;
         default: begin
            req_bus.ready = 1'b0;
         end
      endcase
   end

   assign cnt_in = (state_in != state_ff) ? 4'd0 : 4'(cnt_ff + 4'd1);

   assign cand = use_div_ff ? quotient : next_pwm_ff;
   assign diff = (cand >= held_pwm_ff) ? 16'(cand - held_pwm_ff)
                                       : 16'(held_pwm_ff - cand);

   always_comb begin
      held_pwm_in = held_pwm_ff;
      fan_en_in   = fan_en_ff;
      if (finish_fire && auto_ff) begin
         fan_en_in = present_ff;
         if (diff >= threshold_ff) held_pwm_in = cand;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ffsc_pkg::ST_IDLE;
         cnt_ff        <= '0;
         held_pwm_ff   <= '0;
         fan_en_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         speed_low_ff  <= '0;
         speed_mid_ff  <= '0;
         speed_high_ff <= '0;
         threshold_ff  <= '0;
      end else begin
         state_ff    <= state_in;
         cnt_ff      <= cnt_in;
         held_pwm_ff <= held_pwm_in;
         fan_en_ff   <= fan_en_in;
         if (finish_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_bus.valid && csr_bus.ready) begin
            case (csr_bus.reg_index)
               ffsc_pkg::CSR_SPEED_LOW:  speed_low_ff  <= csr_bus.wdata;
               ffsc_pkg::CSR_SPEED_MID:  speed_mid_ff  <= csr_bus.wdata;
               ffsc_pkg::CSR_SPEED_HIGH: speed_high_ff <= csr_bus.wdata;
               ffsc_pkg::CSR_THRESHOLD:  threshold_ff  <= csr_bus.wdata;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         auto_ff     <= req_bus.auto_mode;
         present_ff  <= req_bus.presence;
         next_pwm_ff <= held_pwm_ff;
         use_div_ff  <= 1'b0;
      end else if (state_ff == ffsc_pkg::ST_DLOAD) begin
         if (sum_small) begin
            next_pwm_ff <= speed_low_ff;
         end else begin
            use_div_ff <= 1'b1;
         end
      end
      if (finish_fire) begin
         rsp_fan_ff <= fan_en_in;
         rsp_pwm_ff <= held_pwm_in;
      end
   end

   assign csr_bus.ready     = 1'b1;
   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.fan_on    = rsp_fan_ff;
   assign rsp_bus.pwm_value = rsp_pwm_ff;

   a_held_only_on_finish: assert property (@(posedge clock) disable iff (reset)
      !$stable(held_pwm_ff) |-> $past(finish_fire))
      else $error("Held PWM changed outside the finishing step.");

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ffsc_pkg::ST_FINISH))
      else $error("Response raised without a finished item.");

   a_divide_sum_floor: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ffsc_pkg::ST_DIVIDE) |-> (mac_sum >= ffsc_pkg::SUM_FLOOR))
      else $error("Division started with a weight sum below the floor.");

   a_quotient_bound: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ffsc_pkg::ST_FINISH) && use_div_ff) |->
         ((quotient <= speed_low_ff) || (quotient <= speed_mid_ff) ||
          (quotient <= speed_high_ff)))
      else $error("Weighted average exceeds every speed register.");

endmodule
